@@ design/url_scheme_host_splitter_top_assert.svh @@
// assertion macros for the url scheme and host splitter checks
`ifndef URL_SCHEME_HOST_SPLITTER_TOP_ASSERT_SVH
`define URL_SCHEME_HOST_SPLITTER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define USHS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ushs check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define USHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ushs check failed");

`endif

@@ design/ushs_pkg.sv @@
// types, codes and character helpers for the url scheme and host splitter
`default_nettype none

package ushs_pkg;

  localparam int SCHEME_MAX = 9;
  localparam int HOST_MAX   = 63;
  localparam int CNT_MAX    = (HOST_MAX > SCHEME_MAX) ? HOST_MAX : SCHEME_MAX;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // result kinds
  localparam logic [1:0] KIND_SCHEME  = 2'd0;
  localparam logic [1:0] KIND_HOST    = 2'd1;
  localparam logic [1:0] KIND_RES     = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  // verdict codes
  localparam logic [1:0] VERDICT_NONE   = 2'd0;
  localparam logic [1:0] VERDICT_FILE   = 2'd1;
  localparam logic [1:0] VERDICT_MAILTO = 2'd2;
  localparam logic [1:0] VERDICT_REMOTE = 2'd3;

  typedef enum logic [4:0] {
    PH_SCHEME = 5'b00001,
    PH_AFTER  = 5'b00010,
    PH_HOST   = 5'b00100,
    PH_RES    = 5'b01000,
    PH_FAILED = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] verdict;
    logic       last;
  } item_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
  endfunction

  // "file", one letter per position
  function automatic logic [7:0] file_char(input logic [1:0] idx);
    case (idx)
      2'd0: file_char = 8'h66;
      2'd1: file_char = 8'h69;
      2'd2: file_char = 8'h6C;
      default: file_char = 8'h65;
    endcase
  endfunction

  // "mailto", one letter per position
  function automatic logic [7:0] mailto_char(input logic [2:0] idx);
    case (idx)
      3'd0: mailto_char = 8'h6D;
      3'd1: mailto_char = 8'h61;
      3'd2: mailto_char = 8'h69;
      3'd3: mailto_char = 8'h6C;
      3'd4: mailto_char = 8'h74;
      3'd5: mailto_char = 8'h6F;
      default: mailto_char = 8'h6D;
    endcase
  endfunction

  function automatic item_t mk_item(input logic [1:0] kind, input logic [7:0] data,
                                    input logic [1:0] verdict, input logic last);
    mk_item.kind    = kind;
    mk_item.data    = data;
    mk_item.verdict = verdict;
    mk_item.last    = last;
  endfunction

endpackage

`default_nettype wire

@@ design/url_scheme_host_splitter_top.sv @@
// url scheme and host splitter: byte stream in, classified bytes and verdict out
//
// input channel: one url byte per item (in_byte_i, end_of_url_i on the final byte),
//   accepted at a clock edge with in_valid_i high and in_stall_o low
// output channel: one result item per handshake (part_kind_o, out_byte_o,
//   verdict_o, run_last_o), taken at an edge with out_valid_o high, out_stall_i low
// each url ends with one verdict item carrying run_last_o
// path: an accepted item waits in the input register until the result buffer, which
//   drives the outputs, is empty or is handing over its last result, then loads in
// throughput: one item per cycle while items give at most one result each and
//   out_stall_i is low; the three-slot result buffer drains one result per cycle
//   while unstalled, so an item giving two or three results (held slash, filler
//   slash, verdict) holds the input until the buffer has drained
// when the receiver stalls, the buffer holds its head item steady and the input
//   register fills, then in_stall_o rises; nothing is dropped
// reset: buffers empty, parser back in the scheme phase with match flags set
`default_nettype none

module url_scheme_host_splitter_top import ushs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_url_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      part_kind_o,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      verdict_o,
  output logic            run_last_o
);

  // input register
  logic       in_full_q, in_full_d;
  logic [7:0] byte_q;
  logic       last_q;

  // parser state
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] pcnt_q, pcnt_d;
  logic             slash_q, slash_d;
  logic             file_q, file_d;
  logic             mailto_q, mailto_d;
  logic             empty_q, empty_d;

  // result buffer, slot 0 drives the outputs
  item_t      slot_q [3];
  item_t      slot_d [3];
  logic [1:0] buf_cnt_q, buf_cnt_d;

  // results of the item in the input register
  item_t      res   [3];
  logic [1:0] res_n;
  logic [7:0] lc;

  logic pop, fire, accept;

  assign pop    = (buf_cnt_q != 2'd0) && !out_stall_i;
  // parse when the buffer is empty by the end of this cycle
  assign fire   = in_full_q && ((buf_cnt_q == 2'd0) || ((buf_cnt_q == 2'd1) && pop));
  assign in_stall_o = in_full_q && !fire;
  assign accept = in_valid_i && !in_stall_o;

  assign out_valid_o = (buf_cnt_q != 2'd0);
  assign part_kind_o = slot_q[0].kind;
  assign out_byte_o  = slot_q[0].data;
  assign verdict_o   = slot_q[0].verdict;
  assign run_last_o  = slot_q[0].last;

  always_comb begin
    in_full_d = in_full_q;
    if (accept) begin
      in_full_d = 1'b1;
    end else if (fire) begin
      in_full_d = 1'b0;
    end
  end

  // one parse step: byte handling, then end-of-url tail
  always_comb begin
    phase_d  = phase_q;
    pcnt_d   = pcnt_q;
    slash_d  = slash_q;
    file_d   = file_q;
    mailto_d = mailto_q;
    empty_d  = empty_q;
    res_n    = 2'd0;
    lc       = to_lower(byte_q);
    for (int i = 0; i < 3; i++) begin
      res[i] = mk_item(KIND_RES, CHAR_NUL, VERDICT_NONE, 1'b0);
    end

    case (phase_q)
      PH_SCHEME: begin
        if (is_letter(byte_q)) begin
          if (pcnt_q < CNT_W'(SCHEME_MAX)) begin
            file_d   = file_q && (pcnt_q < CNT_W'(4)) && (lc == file_char(pcnt_q[1:0]));
            mailto_d = mailto_q && (pcnt_q < CNT_W'(6)) && (lc == mailto_char(pcnt_q[2:0]));
            pcnt_d   = pcnt_q + CNT_W'(1);
            res[res_n] = mk_item(KIND_SCHEME, lc, VERDICT_NONE, 1'b0);
            res_n      = res_n + 2'd1;
          end else begin
            phase_d = PH_FAILED;
          end
        end else if (byte_q == CHAR_COLON && pcnt_q >= CNT_W'(2)) begin
          file_d   = file_q && (pcnt_q == CNT_W'(4));
          mailto_d = mailto_q && (pcnt_q == CNT_W'(6));
          pcnt_d   = '0;
          phase_d  = PH_AFTER;
        end else begin
          phase_d = PH_FAILED;
        end
      end
      PH_AFTER: begin
        if (slash_q) begin
          slash_d = 1'b0;
          if (byte_q == CHAR_SLASH) begin
            phase_d = PH_HOST;
          end else begin
            res[res_n] = mk_item(KIND_RES, CHAR_SLASH, VERDICT_NONE, 1'b0);
            res_n      = res_n + 2'd1;
            res[res_n] = mk_item(KIND_RES, byte_q, VERDICT_NONE, 1'b0);
            res_n      = res_n + 2'd1;
            empty_d    = 1'b0;
            phase_d    = PH_RES;
          end
        end else if (byte_q == CHAR_SLASH) begin
          slash_d = 1'b1;
        end else begin
          res[res_n] = mk_item(KIND_RES, byte_q, VERDICT_NONE, 1'b0);
          res_n      = res_n + 2'd1;
          empty_d    = 1'b0;
          phase_d    = PH_RES;
        end
      end
      PH_HOST: begin
        // a slash or an overlong host switches to resource
        if (byte_q == CHAR_SLASH || pcnt_q >= CNT_W'(HOST_MAX)) begin
          res[res_n] = mk_item(KIND_RES, byte_q, VERDICT_NONE, 1'b0);
          res_n      = res_n + 2'd1;
          empty_d    = 1'b0;
          phase_d    = PH_RES;
        end else begin
          res[res_n] = mk_item(KIND_HOST, lc, VERDICT_NONE, 1'b0);
          res_n      = res_n + 2'd1;
          pcnt_d     = pcnt_q + CNT_W'(1);
        end
      end
      PH_RES: begin
        res[res_n] = mk_item(KIND_RES, byte_q, VERDICT_NONE, 1'b0);
        res_n      = res_n + 2'd1;
        empty_d    = 1'b0;
      end
      default: begin
      end
    endcase

    if (last_q) begin
      if (phase_d == PH_SCHEME || phase_d == PH_FAILED) begin
        res[res_n] = mk_item(KIND_VERDICT, CHAR_NUL, VERDICT_NONE, 1'b1);
        res_n      = res_n + 2'd1;
      end else begin
        // a held slash goes out first, then a filler slash for an empty resource
        if (slash_d) begin
          res[res_n] = mk_item(KIND_RES, CHAR_SLASH, VERDICT_NONE, 1'b0);
          res_n      = res_n + 2'd1;
          empty_d    = 1'b0;
        end
        if (empty_d) begin
          res[res_n] = mk_item(KIND_RES, CHAR_SLASH, VERDICT_NONE, 1'b0);
          res_n      = res_n + 2'd1;
        end
        res[res_n] = mk_item(KIND_VERDICT, CHAR_NUL,
                             file_d ? VERDICT_FILE : (mailto_d ? VERDICT_MAILTO : VERDICT_REMOTE),
                             1'b1);
        res_n      = res_n + 2'd1;
      end
      // back to reset state for the next url
      phase_d  = PH_SCHEME;
      pcnt_d   = '0;
      slash_d  = 1'b0;
      file_d   = 1'b1;
      mailto_d = 1'b1;
      empty_d  = 1'b1;
    end
  end

  // result buffer: load on a parse step, else shift on a pop
  always_comb begin
    slot_d    = slot_q;
    buf_cnt_d = buf_cnt_q;
    if (fire) begin
      slot_d    = res;
      buf_cnt_d = res_n;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      buf_cnt_d = buf_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
      buf_cnt_q <= 2'd0;
      phase_q   <= PH_SCHEME;
      pcnt_q    <= '0;
      slash_q   <= 1'b0;
      file_q    <= 1'b1;
      mailto_q  <= 1'b1;
      empty_q   <= 1'b1;
    end else begin
      in_full_q <= in_full_d;
      buf_cnt_q <= buf_cnt_d;
      if (fire) begin
        phase_q  <= phase_d;
        pcnt_q   <= pcnt_d;
        slash_q  <= slash_d;
        file_q   <= file_d;
        mailto_q <= mailto_d;
        empty_q  <= empty_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      last_q <= end_of_url_i;
    end
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

@@ design/ushs_checker.sv @@
// port-level checks for the url scheme and host splitter, bound to the top level
`default_nettype none

`include "url_scheme_host_splitter_top_assert.svh"

module ushs_checker import ushs_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] in_byte_i,
  input wire logic       end_of_url_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] part_kind_o,
  input wire logic [7:0] out_byte_o,
  input wire logic [1:0] verdict_o,
  input wire logic       run_last_o
);

  // a stalled input item holds still
  `USHS_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o,
    in_valid_i && $stable(in_byte_i) && $stable(end_of_url_i))

  // a stalled result holds still
  `USHS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(part_kind_o) && $stable(out_byte_o) && $stable(verdict_o)
    && $stable(run_last_o))

  // run_last exactly on verdict items, which carry a zero byte; others carry no verdict
  `USHS_ASSERT_NOW(a_verdict_form, out_valid_o,
    (part_kind_o == KIND_VERDICT) == run_last_o
    && (run_last_o || verdict_o == VERDICT_NONE)
    && (!run_last_o || out_byte_o == CHAR_NUL))

  // scheme bytes are lowercase letters
  `USHS_ASSERT_NOW(a_scheme_lower, out_valid_o && part_kind_o == KIND_SCHEME,
    out_byte_o >= 8'h61 && out_byte_o <= 8'h7A)

  // host bytes carry no uppercase letter and no slash
  `USHS_ASSERT_NOW(a_host_lower, out_valid_o && part_kind_o == KIND_HOST,
    !(out_byte_o >= 8'h41 && out_byte_o <= 8'h5A) && out_byte_o != CHAR_SLASH)

endmodule

bind url_scheme_host_splitter_top ushs_checker u_ushs_checker (.*);

`default_nettype wire
